[rtl/svcd_pkg.sv]
// ----------------------------------------------------------------------------
// svcd_pkg
// Shared types and constants of the soft-vote class change detector.
// ----------------------------------------------------------------------------
package svcd_pkg;

    localparam int SCORE_W    = 8;
    localparam int NUM_INPUTS = 4;
    localparam int POOL_W     = 32;
    localparam int OLD_W      = POOL_W + 1;
    localparam int IN_W       = NUM_INPUTS * SCORE_W;
    localparam int OUT_W      = 8;
    localparam int CLS_OUT_W  = 2;

    localparam int WARMUP_W   = 7;
    localparam int NEG_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [WARMUP_W-1:0] WARMUP_RESET = 7'd5;
    localparam logic [NEG_W-1:0]    NEG_RESET    = 2'd0;

    localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_CLASS = 1'd1;

    localparam logic signed [POOL_W-1:0] POOL_MAX = 32'sh7fff_ffff;
    localparam logic signed [POOL_W-1:0] POOL_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        SENSE_NEG     = 2'd0,
        SENSE_POS     = 2'd1,
        SENSE_UNKNOWN = 2'd2
    } sense_t;

    // per-lane commit controls
    typedef struct packed {
        logic take;
        logic fire;
    } lane_ctl_t;

endpackage

[rtl/soft_vote_class_change_detector_unit.sv]
// ----------------------------------------------------------------------------
// soft_vote_class_change_detector_unit
// A result appears on the m_axis side in the cycle after its request is taken.
// Throughput: one request per cycle while the m_axis side does not stall, set by
// the pool update, older-sum argmax and decision path that feeds the pool registers.
// Reset: pools, window sums and ring rows clear at once, warm-up count loads
// 5, sense becomes unknown; no clearing pass, requests are taken right away.
// ----------------------------------------------------------------------------
module soft_vote_class_change_detector_unit import svcd_pkg::*; #(
    parameter int WINDOW  = 4,
    parameter int CLASSES = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,  // score_0, score_1, score_2, score_3
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // item_winner[1:0], decision_valid,
                                                 // decision_class[1:0], sense_state[1:0], pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RSUM_W = SCORE_W + $clog2(WINDOW);
    localparam int IDX_W  = $clog2(CLASSES);
    localparam int CMP_W  = (IDX_W > CLS_OUT_W) ? IDX_W : CLS_OUT_W;

    logic [WARMUP_W-1:0] warmup_votes_reg, warmup_votes_next;
    logic [NEG_W-1:0]    neg_class_reg, neg_class_next;
    logic [WARMUP_W-1:0] warmup_left_reg, warmup_left_next;
    sense_t              sense_reg, sense_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg, m_data_next;

    logic take;
    logic cfg_take;
    logic fire;
    lane_ctl_t lane_ctl;

    logic signed [SCORE_W-1:0] score  [CLASSES];
    logic signed [RSUM_W-1:0]  recent [CLASSES];
    logic signed [OLD_W-1:0]   older  [CLASSES];

    logic [IDX_W-1:0] item_win;
    logic [IDX_W-1:0] recent_win;
    logic [IDX_W-1:0] older_win;
    logic [CMP_W-1:0] item_win_ext;
    logic [CMP_W-1:0] older_win_ext;
    sense_t           sense_step;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_take      = cfg_valid && cfg_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    generate
        for (genvar c = 0; c < CLASSES; c++) begin : g_lane
            if (c < NUM_INPUTS) begin : g_in
                assign score[c] = s_axis_tdata[c*SCORE_W +: SCORE_W];
            end else begin : g_zero
                assign score[c] = '0;
            end

            svcd_lane #(
                .WINDOW (WINDOW),
                .SLOT_W (SLOT_W),
                .RSUM_W (RSUM_W)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl),
                .wr_slot (slot_reg),
                .rd_slot (slot_next),
                .score   (score[c]),
                .recent  (recent[c]),
                .older   (older[c])
            );
        end
    endgenerate

    svcd_argmax #(.N(CLASSES), .W(SCORE_W), .IW(IDX_W)) u_item_max (
        .val (score),
        .idx (item_win)
    );

    svcd_argmax #(.N(CLASSES), .W(RSUM_W), .IW(IDX_W)) u_recent_max (
        .val (recent),
        .idx (recent_win)
    );

    svcd_argmax #(.N(CLASSES), .W(OLD_W), .IW(IDX_W)) u_older_max (
        .val (older),
        .idx (older_win)
    );

    svcd_decide #(.IDX_W(IDX_W)) u_decide (
        .recent_win (recent_win),
        .older_win  (older_win),
        .neg_class  (neg_class_reg),
        .warm_done  (warmup_left_reg == '0),
        .sense      (sense_reg),
        .fire       (fire),
        .sense_next (sense_step)
    );

    assign lane_ctl.take = take;
    assign lane_ctl.fire = fire;

    always_comb begin
        warmup_votes_next = warmup_votes_reg;
        neg_class_next    = neg_class_reg;
        warmup_left_next  = warmup_left_reg;
        sense_next        = sense_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;
        m_data_next       = m_data_reg;
        item_win_ext      = CMP_W'(item_win);
        older_win_ext     = CMP_W'(older_win);

        if (take) begin
            sense_next = sense_step;
            if (!fire && warmup_left_reg != '0) begin
                warmup_left_next = warmup_left_reg - 1'b1;
            end
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, sense_step,
                            fire ? older_win_ext[CLS_OUT_W-1:0] : {CLS_OUT_W{1'b0}},
                            fire, item_win_ext[CLS_OUT_W-1:0]};
        end

        if (cfg_take) begin
            case (cfg_index)
                REG_WARMUP: begin
                    warmup_votes_next = cfg_data[WARMUP_W-1:0];
                    warmup_left_next  = cfg_data[WARMUP_W-1:0];
                end
                REG_NEG_CLASS: begin
                    neg_class_next = cfg_data[NEG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_votes_reg <= WARMUP_RESET;
            neg_class_reg    <= NEG_RESET;
            warmup_left_reg  <= WARMUP_RESET;
            sense_reg        <= SENSE_UNKNOWN;
            slot_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            warmup_votes_reg <= warmup_votes_next;
            neg_class_reg    <= neg_class_next;
            warmup_left_reg  <= warmup_left_next;
            sense_reg        <= sense_next;
            m_valid_reg      <= m_valid_next;
            if (take) begin
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // once a sense is known it never returns to unknown
    a_sense_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (sense_reg != SENSE_UNKNOWN) |=> (sense_reg != SENSE_UNKNOWN))
        else $error("sense fell back to unknown");

    // a decision only fires once the warm-up count is exhausted
    a_fire_after_warmup: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && fire) |-> (warmup_left_reg == '0))
        else $error("decision during warm-up");

    // an accepted request without decision counts the warm-up down by one
    a_warmup_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !fire && !cfg_take && warmup_left_reg != '0)
        |=> (warmup_left_reg == $past(warmup_left_reg) - 1'b1))
        else $error("warm-up count did not step");

    // every taken request leaves a result pending
    a_take_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("result lost");

endmodule

[rtl/svcd_argmax.sv]
// ----------------------------------------------------------------------------
// svcd_argmax
// Balanced compare tree returning the index of the largest signed value,
// lowest index on ties.
// ----------------------------------------------------------------------------
module svcd_argmax #(
    parameter int N  = 4,
    parameter int W  = 8,
    parameter int IW = 2
) (
    input  logic signed [W-1:0] val [N],
    output logic [IW-1:0]       idx
);

    localparam int P = 1 << IW;

    logic signed [W-1:0] node_val [2*P-1];
    logic [IW-1:0]       node_idx [2*P-1];

    always_comb begin
        for (int i = 0; i < P; i++) begin
            // padding leaves hold the minimum so a real entry always wins the tie
            node_val[P-1+i] = (i < N) ? val[i] : {1'b1, {(W-1){1'b0}}};
            node_idx[P-1+i] = IW'(i);
        end
        for (int k = P - 2; k >= 0; k--) begin
            if (node_val[2*k+2] > node_val[2*k+1]) begin
                node_val[k] = node_val[2*k+2];
                node_idx[k] = node_idx[2*k+2];
            end else begin
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end
        end
        idx = node_idx[0];
    end

endmodule

[rtl/svcd_lane.sv]
// ----------------------------------------------------------------------------
// svcd_lane
// One class lane: saturating pool sum, ring of recent scores with a running
// window sum, and the older sum (pool minus window sum).
// ----------------------------------------------------------------------------
module svcd_lane import svcd_pkg::*; #(
    parameter int WINDOW = 4,
    parameter int SLOT_W = 2,
    parameter int RSUM_W = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctl_t                ctl,
    input  logic [SLOT_W-1:0]        wr_slot,
    input  logic [SLOT_W-1:0]        rd_slot,
    input  logic signed [SCORE_W-1:0] score,
    output logic signed [RSUM_W-1:0] recent,
    output logic signed [OLD_W-1:0]  older
);

    logic signed [SCORE_W-1:0] ring_mem [WINDOW];
    logic [WINDOW-1:0]         row_valid_reg;
    logic signed [SCORE_W-1:0] evict_row_reg;
    logic signed [RSUM_W-1:0]  rsum_reg;
    logic signed [POOL_W-1:0]  pool_reg;

    logic signed [OLD_W-1:0]   pool_sum;
    logic signed [POOL_W-1:0]  pool_sat;
    logic signed [RSUM_W-1:0]  rsum_next;
    logic signed [POOL_W-1:0]  pool_next;
    logic signed [SCORE_W-1:0] evict_val;

    always_comb begin
        pool_sum = {pool_reg[POOL_W-1], pool_reg}
                 + {{(OLD_W-SCORE_W){score[SCORE_W-1]}}, score};
        if (pool_sum[OLD_W-1] != pool_sum[OLD_W-2]) begin
            pool_sat = pool_sum[OLD_W-1] ? POOL_MIN : POOL_MAX;
        end else begin
            pool_sat = pool_sum[POOL_W-1:0];
        end

        // evict_val already holds the row about to be overwritten
        rsum_next = rsum_reg
                  + {{(RSUM_W-SCORE_W){score[SCORE_W-1]}}, score}
                  - {{(RSUM_W-SCORE_W){evict_val[SCORE_W-1]}}, evict_val};

        older = {pool_sat[POOL_W-1], pool_sat}
              - {{(OLD_W-RSUM_W){rsum_next[RSUM_W-1]}}, rsum_next};
        recent = rsum_next;

        pool_next = ctl.fire ? {{(POOL_W-RSUM_W){rsum_next[RSUM_W-1]}}, rsum_next}
                             : pool_sat;
    end

    // next row to evict; with a one-row window it is the row being written
    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            ring_mem[wr_slot] <= score;
            if (rd_slot == wr_slot) begin
                evict_row_reg <= score;
            end else begin
                evict_row_reg <= ring_mem[rd_slot];
            end
        end
    end

    logic evict_src_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg       <= '0;
            rsum_reg            <= '0;
            pool_reg            <= '0;
            evict_src_valid_reg <= 1'b0;
        end else if (ctl.take) begin
            row_valid_reg[wr_slot] <= 1'b1;
            rsum_reg               <= rsum_next;
            pool_reg               <= pool_next;
            evict_src_valid_reg    <= (rd_slot == wr_slot) || row_valid_reg[rd_slot];
        end
    end

    assign evict_val = evict_src_valid_reg ? evict_row_reg : '0;

endmodule

[rtl/svcd_decide.sv]
// ----------------------------------------------------------------------------
// svcd_decide
// Merging stage: compares the senses of the recent and older winners with
// the remembered sense and produces the decision and the next sense.
// ----------------------------------------------------------------------------
module svcd_decide import svcd_pkg::*; #(
    parameter int IDX_W = 2
) (
    input  logic [IDX_W-1:0] recent_win,
    input  logic [IDX_W-1:0] older_win,
    input  logic [NEG_W-1:0] neg_class,
    input  logic             warm_done,
    input  sense_t           sense,
    output logic             fire,
    output sense_t           sense_next
);

    localparam int CMP_W = (IDX_W > NEG_W) ? IDX_W : NEG_W;

    logic pos_old;
    logic pos_recent;

    always_comb begin
        pos_old    = CMP_W'(older_win) != CMP_W'(neg_class);
        pos_recent = CMP_W'(recent_win) != CMP_W'(neg_class);

        fire = ((sense == SENSE_UNKNOWN) || ({1'b0, pos_old} != sense))
             && (pos_old != pos_recent)
             && warm_done;

        sense_next = sense;
        if (fire) begin
            case (sense)
                SENSE_UNKNOWN: sense_next = pos_old ? SENSE_POS : SENSE_NEG;
                SENSE_POS:     sense_next = SENSE_NEG;
                SENSE_NEG:     sense_next = SENSE_POS;
                default:       sense_next = sense;
            endcase
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft-vote class change detector testbench
// Feeds score vectors through the stream input and checks every verdict on
// the stream output against a cycle-free model of the vote pool, the score
// window, the warm-up count and the remembered sense. Runs a directed set,
// then random runs of dominant classes mixed with noise under several
// register settings and three idling profiles.
// ----------------------------------------------------------------------------
module testbench import svcd_pkg::*; ();

    localparam int HALF_PERIOD     = 6;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_PHASES      = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 5;
    localparam int RING_DEPTH      = 4;
    localparam int CLASS_COUNT     = 4;

    typedef struct packed {
        logic [1:0] sense;
        logic [1:0] cls;
        logic       fired;
        logic [1:0] winner;
    } verdict_t;

    class decision_scoreboard;
        logic [WARMUP_W-1:0] warmup_votes = WARMUP_RESET;
        logic [WARMUP_W-1:0] warmup_left  = WARMUP_RESET;
        logic [NEG_W-1:0]    neg_class    = NEG_RESET;
        logic signed [POOL_W-1:0]  pool [CLASS_COUNT];
        logic signed [SCORE_W-1:0] window_row [RING_DEPTH][CLASS_COUNT];
        int     slot = 0;
        sense_t sense = SENSE_UNKNOWN;
        verdict_t verdict_q [$];
        int     mismatches = 0;

        function void clear_state();
            for (int c = 0; c < CLASS_COUNT; c++) begin
                pool[c] = '0;
                for (int r = 0; r < RING_DEPTH; r++) window_row[r][c] = '0;
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_WARMUP: begin
                    warmup_votes = val[WARMUP_W-1:0];
                    warmup_left  = val[WARMUP_W-1:0];
                end
                REG_NEG_CLASS: begin
                    neg_class = val[NEG_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function logic signed [POOL_W-1:0] clamp(input longint v);
            if (v > longint'(POOL_MAX)) return POOL_MAX;
            if (v < longint'(POOL_MIN)) return POOL_MIN;
            return v[POOL_W-1:0];
        endfunction

        // lowest index wins ties
        function logic [1:0] pick_best(input longint v [CLASS_COUNT]);
            int best;
            best = 0;
            for (int c = 1; c < CLASS_COUNT; c++)
                if (v[c] > v[best]) best = c;
            return best[1:0];
        endfunction

        function void note_scores(input logic [IN_W-1:0] d);
            longint     score [CLASS_COUNT];
            longint     recent [CLASS_COUNT];
            longint     older [CLASS_COUNT];
            logic [1:0] recent_win, older_win;
            logic       pos_old, pos_recent, fire;
            verdict_t   v;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                score[c] = longint'($signed(d[c*SCORE_W +: SCORE_W]));
                pool[c] = clamp(longint'(pool[c]) + score[c]);
                window_row[slot][c] = d[c*SCORE_W +: SCORE_W];
            end
            slot = (slot + 1) % RING_DEPTH;
            v.winner = pick_best(score);
            for (int c = 0; c < CLASS_COUNT; c++) begin
                recent[c] = 0;
                for (int r = 0; r < RING_DEPTH; r++)
                    recent[c] += longint'(window_row[r][c]);
                older[c] = longint'(pool[c]) - recent[c];
            end
            recent_win = pick_best(recent);
            older_win  = pick_best(older);
            pos_old    = (older_win != neg_class);
            pos_recent = (recent_win != neg_class);
            fire = (sense == SENSE_UNKNOWN || {1'b0, pos_old} != sense)
                && pos_old != pos_recent && warmup_left == 0;
            if (fire) begin
                if (sense == SENSE_UNKNOWN)
                    sense = pos_old ? SENSE_POS : SENSE_NEG;
                else
                    sense = (sense == SENSE_POS) ? SENSE_NEG : SENSE_POS;
                for (int c = 0; c < CLASS_COUNT; c++) pool[c] = clamp(recent[c]);
            end else if (warmup_left > 0) begin
                warmup_left = warmup_left - 1'b1;
            end
            v.fired = fire;
            v.cls   = fire ? older_win : 2'd0;
            v.sense = sense;
            verdict_q.push_back(v);
        endfunction

        function void report(input string field, input int exp_val, input int got_val);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", field, exp_val, got_val);
        endfunction

        function void check_verdict(input logic [OUT_W-1:0] d);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                report("result with no request pending, data", 0, d);
                return;
            end
            want = verdict_q.pop_front();
            if (d[1:0] !== want.winner) report("item_winner", want.winner, d[1:0]);
            if (d[2] !== want.fired) report("decision_valid", want.fired, d[2]);
            if (d[4:3] !== want.cls) report("decision_class", want.cls, d[4:3]);
            if (d[6:5] !== want.sense) report("sense_state", want.sense, d[6:5]);
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;  // score_0, score_1, score_2, score_3
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;  // item_winner[1:0], decision_valid,
                                          // decision_class[1:0], sense_state[1:0], pad
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    decision_scoreboard sb = new;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    soft_vote_class_change_detector_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.note_scores(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_scores(input logic [IN_W-1:0] d);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // one class clearly ahead, the rest random below it
    task automatic send_run(input int cls, input int len);
        logic [IN_W-1:0] d;
        int v;
        for (int i = 0; i < len; i++) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                v = (c == cls) ? $urandom_range(60, 127) : $urandom_range(0, 168) - 128;
                d[c*SCORE_W +: SCORE_W] = v[7:0];
            end
            send_scores(d);
        end
    endtask

    // two lanes share the top score
    task automatic send_tie();
        logic [IN_W-1:0] d;
        int a, b, v;
        a = $urandom_range(0, 3);
        b = (a + $urandom_range(1, 3)) % CLASS_COUNT;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            v = (c == a || c == b) ? 127 : $urandom_range(0, 254) - 128;
            d[c*SCORE_W +: SCORE_W] = v[7:0];
        end
        send_scores(d);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input int warm, input int neg);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WARMUP;
        cfg_data  <= warm[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_NEG_CLASS;
        cfg_data  <= neg[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idling(input int phase);
        if (phase < 2) begin
            tx_idle_pct = 11;
            rx_idle_pct = 84;
        end else if (phase < 4) begin
            tx_idle_pct = 84;
            rx_idle_pct = 11;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    initial begin
        int warm_set [NUM_PHASES];
        int neg_set [NUM_PHASES];
        int sent, pick, len;
        warm_set = '{0, 127, 1, 0, 64, 0};
        neg_set  = '{3, 1, 2, 0, 3, 1};
        sb.clear_state();
        set_idling(0);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, ties, then class swings once the warm-up is over
        send_scores({4{8'h80}});
        send_scores({4{8'h7f}});
        send_scores({4{8'h00}});
        send_scores({8'h7f, 8'h80, 8'h80, 8'h80});
        send_scores({8'h80, 8'h7f, 8'h7f, 8'h80});
        send_scores({8'hff, 8'h80, 8'hff, 8'h80});
        send_scores(32'h55aa55aa);
        send_scores(32'haa55aa55);
        send_run(2, 7);
        send_run(0, 6);
        send_run(1, 4);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(warm_set[p], neg_set[p]);
            set_idling(p);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    len = $urandom_range(2, 10);
                    send_run($urandom_range(0, 3), len);
                    sent += len;
                end else if (pick < 9) begin
                    send_scores($urandom);
                    sent++;
                end else begin
                    send_tie();
                    sent++;
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
